>>> src/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg - shared types and constants of the subscription message parser
// Result codes, field widths, the request prefix and the result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	// Width of a parsed payload length; lengths above 2^LENGTH_BITS-1 are too large
	localparam int unsigned LENGTH_BITS = 16;
	localparam int unsigned ACC_BITS    = LENGTH_BITS + 1;
	localparam int unsigned PREFIX_LEN  = 7;
	localparam int unsigned PM_BITS     = $clog2(PREFIX_LEN + 1);

	// Result kinds
	typedef enum logic [2:0] {
		KIND_TOPIC     = 3'd0,
		KIND_ACCEPTED  = 3'd1,
		KIND_MALFORMED = 3'd2,
		KIND_TOO_LARGE = 3'd3,
		KIND_PAYLOAD   = 3'd4
	} kind_t;

	// Character codes
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_VTAB    = 8'h0B;
	localparam logic [7:0] CH_FFEED   = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] payload_length;
		logic        last;
	} result_t;

	// Prefix text "+SMSUB:" indexed by match position
	function automatic logic [7:0] prefix_char(input logic [PM_BITS-1:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h2B; // '+'
			3'd1:    ch = 8'h53; // 'S'
			3'd2:    ch = 8'h4D; // 'M'
			3'd3:    ch = 8'h53; // 'S'
			3'd4:    ch = 8'h55; // 'U'
			3'd5:    ch = 8'h42; // 'B'
			3'd6:    ch = 8'h3A; // ':'
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

>>> src/msp_in_stage.sv
// ----------------------------------------------------------------------------
// msp_in_stage - input register
// Captures one received byte per request and holds it until the parser steps.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       step,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// Take a new request when empty or when the held byte moves on this cycle
	assign in_ready = !valid_s1 || step;

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold byte
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

`default_nettype wire

>>> src/msp_parser.sv
// ----------------------------------------------------------------------------
// msp_parser - header and payload state machine
// Hunts for the prefix, parses topic and length, then counts payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   byte_s1,
	output logic              res_valid,
	output msp_pkg::result_t  res
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		NP_SPACE,
		NP_SIGN,
		NP_DIGITS,
		NP_DONE
	} num_phase_t;

	localparam int unsigned LB = msp_pkg::LENGTH_BITS;
	localparam int unsigned AB = msp_pkg::ACC_BITS;
	localparam int unsigned PB = msp_pkg::PM_BITS;
	localparam int unsigned MB = AB + 4;

	phase_t                 phase_q,    phase_d;
	logic [PB-1:0]          pm_q,       pm_d;
	logic [1:0]             quotes_q,   quotes_d;
	logic                   comma_q,    comma_d;
	num_phase_t             np_q,       np_d;
	logic                   neg_q,      neg_d;
	logic [AB-1:0]          acc_q,      acc_d;
	logic [LB-1:0]          rem_q,      rem_d;

	logic [7:0]             b;
	logic                   is_digit;
	logic                   is_space;
	logic [MB-1:0]          acc_mul;
	logic [AB-1:0]          acc_next;
	logic                   bad;
	logic [PB-1:0]          pm_inc;

	assign b        = byte_s1;
	assign is_digit = (b >= msp_pkg::CH_ZERO) && (b <= msp_pkg::CH_NINE);
	assign is_space = (b == msp_pkg::CH_SPACE) || (b == msp_pkg::CH_TAB) ||
	                  (b == msp_pkg::CH_VTAB)  || (b == msp_pkg::CH_FFEED) ||
	                  (b == msp_pkg::CH_CR);

	// Accumulate one decimal digit, saturate one above the limit
	assign acc_mul = (MB'(acc_q) << 3) + (MB'(acc_q) << 1) + MB'(b - msp_pkg::CH_ZERO);
	assign acc_next = (acc_mul[MB-1:LB] != '0) ? {1'b1, {LB{1'b0}}} : acc_mul[AB-1:0];

	assign bad = (quotes_q < 2'd2) || !comma_q || (neg_q && (acc_q != '0));
	assign pm_inc = pm_q + PB'(1);

	// Next state and result
	always_comb begin
		phase_d   = phase_q;
		pm_d      = pm_q;
		quotes_d  = quotes_q;
		comma_d   = comma_q;
		np_d      = np_q;
		neg_d     = neg_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res.kind           = msp_pkg::KIND_TOPIC;
		res.out_byte       = 8'd0;
		res.payload_length = 16'd0;
		res.last           = 1'b0;

		unique case (phase_q)
			PH_PAYLOAD: begin
				rem_d        = rem_q - LB'(1);
				res_valid    = 1'b1;
				res.kind     = msp_pkg::KIND_PAYLOAD;
				res.out_byte = b;
				if (rem_q == LB'(1)) begin
					res.last = 1'b1;
					phase_d  = PH_HUNT;
				end
			end

			PH_HEADER: begin
				if (b == msp_pkg::CH_NEWLINE) begin
					// Judge the header
					phase_d   = PH_HUNT;
					pm_d      = '0;
					res_valid = 1'b1;
					if (bad) begin
						res.kind = msp_pkg::KIND_MALFORMED;
					end else if (acc_q[AB-1]) begin
						res.kind = msp_pkg::KIND_TOO_LARGE;
					end else if (acc_q == '0) begin
						res.kind = msp_pkg::KIND_ACCEPTED;
						res.last = 1'b1;
					end else begin
						res.kind           = msp_pkg::KIND_ACCEPTED;
						res.payload_length = 16'(acc_q[LB-1:0]);
						rem_d              = acc_q[LB-1:0];
						phase_d            = PH_PAYLOAD;
					end
				end else begin
					// Length field: restart at every comma
					if (b == msp_pkg::CH_COMMA) begin
						comma_d = 1'b1;
						np_d    = NP_SPACE;
						neg_d   = 1'b0;
						acc_d   = '0;
					end else if (comma_q && (np_q != NP_DONE)) begin
						if (is_digit) begin
							acc_d = acc_next;
							np_d  = NP_DIGITS;
						end else if (np_q == NP_SPACE) begin
							if (is_space) begin
								np_d = NP_SPACE;
							end else if (b == msp_pkg::CH_MINUS) begin
								neg_d = 1'b1;
								np_d  = NP_SIGN;
							end else if (b == msp_pkg::CH_PLUS) begin
								np_d = NP_SIGN;
							end else begin
								np_d = NP_DONE;
							end
						end else begin
							np_d = NP_DONE;
						end
					end
					// Topic: bytes inside the first quoted span
					if (b == msp_pkg::CH_QUOTE) begin
						if (quotes_q < 2'd2) begin
							quotes_d = quotes_q + 2'd1;
						end
					end else if (quotes_q == 2'd1) begin
						res_valid    = 1'b1;
						res.kind     = msp_pkg::KIND_TOPIC;
						res.out_byte = b;
					end
				end
			end

			PH_HUNT: begin
				// Advance the prefix match or restart it
				if ((pm_q < PB'(msp_pkg::PREFIX_LEN)) && (b == msp_pkg::prefix_char(pm_q))) begin
					pm_d = pm_inc;
				end else begin
					pm_d = (b == msp_pkg::CH_PLUS) ? PB'(1) : PB'(0);
				end
				if (pm_d >= PB'(msp_pkg::PREFIX_LEN)) begin
					pm_d     = '0;
					phase_d  = PH_HEADER;
					quotes_d = 2'd0;
					comma_d  = 1'b0;
					np_d     = NP_SPACE;
					neg_d    = 1'b0;
					acc_d    = '0;
				end
			end

			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			pm_q     <= '0;
			quotes_q <= 2'd0;
			comma_q  <= 1'b0;
			np_q     <= NP_SPACE;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			rem_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			pm_q     <= pm_d;
			quotes_q <= quotes_d;
			comma_q  <= comma_d;
			np_q     <= np_d;
			neg_q    <= neg_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
		end
	end

endmodule

`default_nettype wire

>>> src/msp_out_stage.sv
// ----------------------------------------------------------------------------
// msp_out_stage - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire msp_pkg::result_t res,
	input  wire logic             out_ready,
	output logic                  free,
	output logic                  out_valid,
	output msp_pkg::result_t      res_q
);

	// Space for a new result when empty or draining this cycle
	assign free = !out_valid || out_ready;

	// Hold valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> src/modem_sub_message_parser_top.sv
// ----------------------------------------------------------------------------
// modem_sub_message_parser_top - subscription message parser
// Extracts topic bytes, header verdicts and payload bytes from a modem stream.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle unless the result side stalls, and gives
// at most one result per byte. A byte passes through an input register and a
// result register; the whole parse step is one pass of logic between them and
// sustains one byte every cycle while the result register drains. in_ready
// follows out_ready combinationally through the two register stages, and a
// byte that produces no result (prefix hunting, quotes, stray CRLF) still
// moves the parser state on. Payload lengths are limited to 16 bits; larger
// values are reported as too large and the header is dropped.
`default_nettype none

module modem_sub_message_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       out_byte,
	output logic [15:0]      payload_length,
	output logic             last
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             free;
	logic             step;
	logic             res_valid;
	msp_pkg::result_t res;
	msp_pkg::result_t res_q;

	// Step the parser when a byte is held and the result register has room
	assign step = valid_s1 && free;

	msp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.step      (step),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	msp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	msp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.free      (free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign kind           = res_q.kind;
	assign out_byte       = res_q.out_byte;
	assign payload_length = res_q.payload_length;
	assign last           = res_q.last;

endmodule

`default_nettype wire

>>> src/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker - port-level checks of the subscription message parser
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [7:0]  out_byte,
	input wire logic [15:0] payload_length,
	input wire logic        last
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte) &&
		$stable(payload_length) && $stable(last))
		else $error("result changed while stalled");

	// Length only on an accepted header
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != msp_pkg::KIND_ACCEPTED) |-> payload_length == 16'd0)
		else $error("length on a non-header result");

	// Header verdicts carry no byte
	a_hdr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == msp_pkg::KIND_ACCEPTED || kind == msp_pkg::KIND_MALFORMED ||
		kind == msp_pkg::KIND_TOO_LARGE) |-> out_byte == 8'd0)
		else $error("byte on a header result");

	// Last marks only a final payload byte or an empty accepted header
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> (kind == msp_pkg::KIND_PAYLOAD) ||
		(kind == msp_pkg::KIND_ACCEPTED && payload_length == 16'd0))
		else $error("last on a wrong result");

endmodule

bind modem_sub_message_parser_top msp_checker u_msp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.out_byte       (out_byte),
	.payload_length (payload_length),
	.last           (last)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - subscription message parser
// Feeds modem byte streams with framed, broken and stray traffic into the
// parser, predicts every topic byte, header verdict and payload byte, and
// checks each result in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;

	localparam int unsigned LEN_MAX    = (1 << msp_pkg::LENGTH_BITS) - 1;
	localparam int          HANG_LIMIT = 1000;
	localparam logic [55:0] SUB_TAG    = "+SMSUB:";

	typedef enum logic [1:0] {P_HUNT, P_HEADER, P_BODY} parse_phase_t;
	typedef enum logic [1:0] {N_SPACE, N_SIGN, N_DIGITS, N_DONE} num_state_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic [15:0] payload_length;
	logic        last;

	// Predicted parser state
	parse_phase_t parse_phase = P_HUNT;
	num_state_t   num_state   = N_SPACE;
	logic [2:0]   tag_pos     = 3'd0;
	logic [1:0]   quotes_seen = 2'd0;
	logic         got_comma   = 1'b0;
	logic         num_neg     = 1'b0;
	int unsigned  len_acc     = 0;
	int unsigned  body_left   = 0;

	msp_pkg::result_t due_results[$];

	int   mismatches  = 0;
	int   bytes_sent  = 0;
	int   burst_left  = 0;
	bit   tx_bursty   = 1'b1;
	logic rx_stalls   = 1'b1;
	logic [5:0]  rx_tick    = 6'd0;
	logic [15:0] rx_pattern = '1;
	int   quiet_cycles = 0;

	modem_sub_message_parser_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.out_byte       (out_byte),
		.payload_length (payload_length),
		.last           (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic void queue_result(input msp_pkg::kind_t k, input logic [7:0] b,
			input logic [15:0] n, input logic l);
		msp_pkg::result_t r;
		r.kind           = k;
		r.out_byte       = b;
		r.payload_length = n;
		r.last           = l;
		due_results.push_back(r);
	endfunction

	// Advance the predicted parser by one request
	function automatic void parse_byte(input logic [7:0] b);
		logic malformed;
		int   tp;
		if (parse_phase == P_BODY) begin
			// payload bytes pass straight through, the final one marked
			body_left--;
			if (body_left == 0) begin
				parse_phase = P_HUNT;
				queue_result(msp_pkg::KIND_PAYLOAD, b, 16'd0, 1'b1);
			end else begin
				queue_result(msp_pkg::KIND_PAYLOAD, b, 16'd0, 1'b0);
			end
		end else if (parse_phase == P_HEADER) begin
			if (b == msp_pkg::CH_NEWLINE) begin
				// judge the header
				malformed = quotes_seen < 2 || !got_comma || (num_neg && len_acc != 0);
				parse_phase = P_HUNT;
				tag_pos = 3'd0;
				if (malformed) begin
					queue_result(msp_pkg::KIND_MALFORMED, 8'd0, 16'd0, 1'b0);
				end else if (len_acc > LEN_MAX) begin
					queue_result(msp_pkg::KIND_TOO_LARGE, 8'd0, 16'd0, 1'b0);
				end else if (len_acc == 0) begin
					queue_result(msp_pkg::KIND_ACCEPTED, 8'd0, 16'd0, 1'b1);
				end else begin
					body_left = len_acc;
					parse_phase = P_BODY;
					queue_result(msp_pkg::KIND_ACCEPTED, 8'd0, 16'(len_acc), 1'b0);
				end
			end else begin
				// every comma restarts the length
				if (b == msp_pkg::CH_COMMA) begin
					got_comma = 1'b1;
					num_state = N_SPACE;
					num_neg = 1'b0;
					len_acc = 0;
				end else if (got_comma && num_state != N_DONE) begin
					if (b >= msp_pkg::CH_ZERO && b <= msp_pkg::CH_NINE) begin
						len_acc = len_acc * 10 + (b - msp_pkg::CH_ZERO);
						if (len_acc > LEN_MAX)
							len_acc = LEN_MAX + 1;
						num_state = N_DIGITS;
					end else if (num_state == N_SPACE) begin
						if (b == msp_pkg::CH_SPACE || b == msp_pkg::CH_TAB ||
								b == msp_pkg::CH_VTAB || b == msp_pkg::CH_FFEED ||
								b == msp_pkg::CH_CR) begin
							num_state = N_SPACE;
						end else if (b == msp_pkg::CH_MINUS) begin
							num_neg = 1'b1;
							num_state = N_SIGN;
						end else if (b == msp_pkg::CH_PLUS) begin
							num_state = N_SIGN;
						end else begin
							num_state = N_DONE;
						end
					end else begin
						num_state = N_DONE;
					end
				end
				// topic lies between the first two quotes
				if (b == msp_pkg::CH_QUOTE) begin
					if (quotes_seen < 2)
						quotes_seen++;
				end else if (quotes_seen == 1) begin
					queue_result(msp_pkg::KIND_TOPIC, b, 16'd0, 1'b0);
				end
			end
		end else begin
			// hunt for the prefix; a stray '+' restarts the match
			tp = tag_pos;
			if (tp < 7 && b == SUB_TAG[8 * (6 - tp) +: 8])
				tag_pos++;
			else
				tag_pos = (b == msp_pkg::CH_PLUS) ? 3'd1 : 3'd0;
			if (tag_pos == 3'd7) begin
				tag_pos = 3'd0;
				parse_phase = P_HEADER;
				quotes_seen = 2'd0;
				got_comma = 1'b0;
				num_state = N_SPACE;
				num_neg = 1'b0;
				len_acc = 0;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Sending side
	// ------------------------------------------------------------------
	// Send one request, opening a new burst after a random gap when due
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (tx_bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		parse_byte(b);
		in_valid  <= 1'b1;
		data_byte <= b;
		bytes_sent++;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Fill whatever payload the last header announced
	task automatic send_body();
		while (parse_phase == P_BODY)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// Hold off the sender until every predicted result is out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	// One message, mostly well formed, with random content
	task automatic random_message();
		int         form;
		int         pick;
		logic [7:0] tb;
		string      digits;
		form = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			send_text("+SMS");
		send_text("+SMSUB:");
		if ($urandom_range(0, 1) == 1)
			push_byte(msp_pkg::CH_SPACE);
		// topic, dropping one or both quotes now and then
		if (form < 90 || form >= 95)
			push_byte(msp_pkg::CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			do tb = 8'($urandom_range(0, 255));
			while (tb == msp_pkg::CH_QUOTE || tb == msp_pkg::CH_NEWLINE);
			push_byte(tb);
		end
		if (form < 90)
			push_byte(msp_pkg::CH_QUOTE);
		if ($urandom_range(0, 5) == 0)
			send_text(",\"x\"");
		// length field; some headers lose their comma
		if (form < 85 || form >= 90)
			push_byte(msp_pkg::CH_COMMA);
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 4))
				0: push_byte(msp_pkg::CH_SPACE);
				1: push_byte(msp_pkg::CH_TAB);
				2: push_byte(msp_pkg::CH_VTAB);
				3: push_byte(msp_pkg::CH_FFEED);
				default: push_byte(msp_pkg::CH_CR);
			endcase
		end
		pick = $urandom_range(0, 9);
		if (pick == 0)
			push_byte(msp_pkg::CH_PLUS);
		else if (pick == 1 || (form >= 80 && form < 85))
			push_byte(msp_pkg::CH_MINUS);
		pick = $urandom_range(0, 99);
		if (form >= 75 && form < 80) begin
			if (pick < 50)
				digits = $sformatf("%0d", $urandom_range(65536, 9999999));
			else
				digits = "184467440737095516160";
		end else if (pick < 60) begin
			digits = $sformatf("%0d", $urandom_range(0, 12));
		end else if (pick < 88) begin
			digits = $sformatf("%0d", $urandom_range(13, 200));
		end else if (pick < 97) begin
			digits = $sformatf("%0d", $urandom_range(201, 700));
		end else begin
			digits = "";
		end
		if ($urandom_range(0, 9) == 0)
			digits = {"00", digits};
		send_text(digits);
		// tail of the header
		pick = $urandom_range(0, 9);
		if (pick < 8)
			push_byte(msp_pkg::CH_CR);
		else if (pick == 8)
			send_text("z7");
		push_byte(msp_pkg::CH_NEWLINE);
		send_body();
	endtask

	// ------------------------------------------------------------------
	// Receiving side
	// ------------------------------------------------------------------
	// Stall on a 16-bit ready pattern, redrawn each time the 6-bit tick wraps
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (rx_tick == 6'd0) begin
			case ($urandom_range(0, 3))
				0: rx_pattern <= '1;
				1: rx_pattern <= 16'h0001;
				default: rx_pattern <= 16'($urandom) | 16'h0001;
			endcase
		end
		out_ready <= !rx_stalls || rx_pattern[rx_tick[3:0]];
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endtask

	// Compare each result with the oldest prediction
	always @(posedge clk) begin : check_results
		msp_pkg::result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d byte %02h", kind, out_byte));
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, want %02h", out_byte,
						want.out_byte));
				if (payload_length !== want.payload_length)
					report_mismatch($sformatf("payload_length %0d, want %0d", payload_length,
						want.payload_length));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	// Give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= HANG_LIMIT) begin
					$display("FAIL modem_sub_message_parser_top");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_prefix_hunting();
		send_text("\r\nOK\r\n+SMSU");
		push_byte(8'h00);
		push_byte(8'hFF);
		send_text("+SMS+SMSUB:\"a\",2\r\n");
		send_body();
		send_text("\r\n++SMSUB:\"b\",0\r\n");
	endtask

	task automatic test_topic_and_quotes();
		send_text("+SMSUB:\"");
		push_byte(8'h00);
		push_byte(8'hFF);
		send_text("\",4\r\n");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(msp_pkg::CH_NEWLINE);
		push_byte(msp_pkg::CH_PLUS);
		send_text("+SMSUB:\"\",1\r\nZ");
		send_text("+SMSUB:\"a,b\",\"c\",3\r\n");
		send_body();
		send_text("+SMSUB:\"+SMSUB:\",7\r\n+SMSUB:");
	endtask

	task automatic test_length_parsing();
		send_text("+SMSUB:\"w\", ");
		push_byte(msp_pkg::CH_TAB);
		push_byte(msp_pkg::CH_VTAB);
		push_byte(msp_pkg::CH_FFEED);
		push_byte(msp_pkg::CH_CR);
		send_text("12\r\n");
		send_body();
		send_text("+SMSUB:\"p\",+5\r\n");
		send_body();
		send_text("+SMSUB:\"z\",-0\r\n+SMSUB:\"s\",-\r\n+SMSUB:\"s\",+\r\n");
		send_text("+SMSUB:\"n\",abc\r\n+SMSUB:\"d\",- 5\r\n");
		send_text("+SMSUB:\"c\",99,3\r\n");
		send_body();
		send_text("+SMSUB:\"j\",4x7\r\n");
		send_body();
		send_text("+SMSUB:\"q\",0004 9\r\n");
		send_body();
	endtask

	task automatic test_malformed_headers();
		send_text("+SMSUB:t,1\r\n+SMSUB:\"t,1\r\n+SMSUB:\"t\" 5\r\n");
		send_text("+SMSUB:\"t\",-3\r\n+SMSUB:\n");
	endtask

	task automatic test_too_large();
		send_text("+SMSUB:\"big\",65536\r\n");
		send_text("+SMSUB:\"big\",99999999999999999999\r\n");
		send_text("+SMSUB:\"neg\",-99999999999\r\n");
		send_text("+SMSUB:\"ok\",1\r\n");
		send_body();
	endtask

	// A payload long enough to span many stall patterns
	task automatic test_long_payload();
		send_text("+SMSUB:\"L\",200\r\n");
		send_body();
	endtask

	// Back to back requests with the receiver always ready
	task automatic test_full_rate();
		tx_bursty = 1'b0;
		rx_stalls <= 1'b0;
		repeat (4)
			random_message();
		wait_for_results();
		tx_bursty = 1'b1;
		rx_stalls <= 1'b1;
	endtask

	task automatic test_random_traffic();
		int done;
		int mark;
		done = 0;
		while (done < 600) begin
			// stray bytes between messages
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(0, 255)));
			else
				send_text("\r\n");
			mark = bytes_sent;
			random_message();
			done += bytes_sent - mark;
			if ($urandom_range(0, 15) == 0)
				wait_for_results();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_prefix_hunting();
		test_topic_and_quotes();
		wait_for_results();
		test_length_parsing();
		test_malformed_headers();
		test_too_large();
		test_long_payload();
		test_full_rate();
		test_random_traffic();
		wait_for_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS modem_sub_message_parser_top");
		else
			$display("FAIL modem_sub_message_parser_top");
		$finish;
	end

endmodule
